### rtl/assert_macros.svh
// Assertion macros used by the pricer datapath (mcop_dp).
// No dependencies; the SYNTH define turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MCOP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MCOP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MCOP_ASSERT(lbl, clk, rstn, prop, msg)
`define MCOP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/mcop_pkg.sv
// Types and constants of the Monte Carlo option pricer.
// No dependencies; imported by the top level, mcop_ctrl and mcop_dp.
package mcop_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SPOT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN   = 3'd6;

  localparam logic [63:0] LN2_Q32   = 64'h0000_0000_B172_17F8;
  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] U32_MAX64 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd13;

  typedef struct packed {
    logic signed [15:0] gaussian_sample;
    logic               restart;
  } in_t;

  typedef struct packed {
    logic [31:0] running_mean;
    logic [31:0] running_error;
    logic [15:0] block_number;
  } out_t;

  typedef enum logic [3:0] {
    OP_SIG2, OP_DRIFT, OP_SIGZ, OP_KDIV, OP_TMUL, OP_TDIV, OP_SPOT, OP_DISC,
    OP_PAY, OP_MEAN, OP_MSQ, OP_CM, OP_MSQD, OP_CM2, OP_VDIV, OP_SQRT
  } op_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic emit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic taylor_last;
    logic block_end;
    logic multi_block;
    logic out_free;
  } sts_t;

endpackage

### rtl/monte_carlo_option_block_pricer.sv
// Monte Carlo European option pricer with block averaging, top level.
// Depends on mcop_pkg, mcop_ctrl and mcop_dp.
//
// Samples arrive on the input channel (in_valid_i, in_stall_o, in_data_i); a
// transfer takes place when valid is high and stall is low. Each sample is
// priced along one path and added to the current block. When a block closes,
// one result (running mean, error, block count) leaves on the output channel.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must do so only while the block is idle, as the block itself does not
// enforce it; unknown indexes are ignored. Each sample needs two exponentials,
// each one range reduction by a multiplication with the reciprocal of ln 2
// and thirteen Taylor terms, every term waiting on the shared radix-2 divider.
// A closing block adds divisions and, once more than one block has closed, a
// 32-step square root before its result is registered.
// One sample is worked on at a time; the next is taken once the previous one
// is finished, even while a result still waits in the output register.
// While the receiver stalls, the result is held and a further block end waits
// for it. Reset restores the configuration defaults and clears all sums.
module monte_carlo_option_block_pricer #(
  parameter int unsigned MAX_BLOCKS    = 65535,
  parameter int unsigned MAX_BLOCK_LEN = 1048575
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mcop_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mcop_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [mcop_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mcop_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mcop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mcop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcop_dp #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/mcop_mul.sv
// Sequential 64 x 64 bit unsigned multiplier, eight bits of b per cycle.
// Depends on nothing; used by the pricer datapath.
module mcop_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [127:0]  p_o
);

  logic [127:0] a_q, p_q;
  logic [63:0]  b_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {64'd0, a_i};
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= p_q + a_q * 128'(b_q[7:0]);
      a_q <= {a_q[119:0], 8'd0};
      b_q <= {8'd0, b_q[63:8]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

### rtl/mcop_div.sv
// Restoring radix-2 divider, 64-bit quotient, one bit per cycle.
// Depends on nothing; used by the pricer datapath.
module mcop_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] quo_q, rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, quo_q[63]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/mcop_ctrl.sv
// Sequencer of the pricer: steps the datapath through one sample's operations.
// Depends on mcop_pkg for the command and status types.
module mcop_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mcop_pkg::sts_t sts_i,
  output mcop_pkg::cmd_t cmd_o
);
  import mcop_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   second_q, second_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    second_d   = second_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          op_d         = OP_SIG2;
          second_d     = 1'b0;
          state_d      = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          state_d = ST_START;
          unique case (op_q)
            OP_SIG2:  op_d = OP_DRIFT;
            OP_DRIFT: op_d = OP_SIGZ;
            OP_SIGZ:  op_d = OP_KDIV;
            OP_KDIV:  op_d = OP_TMUL;
            OP_TMUL:  op_d = OP_TDIV;
            OP_TDIV: begin
              if (!sts_i.taylor_last) begin
                op_d = OP_TMUL;
              end else if (second_q) begin
                op_d = OP_PAY;
              end else begin
                op_d = OP_SPOT;
              end
            end
            OP_SPOT:  op_d = OP_DISC;
            OP_DISC: begin
              op_d     = OP_KDIV;
              second_d = 1'b1;
            end
            OP_PAY: begin
              if (sts_i.block_end) begin
                op_d = OP_MEAN;
              end else begin
                state_d = ST_IDLE;
              end
            end
            OP_MEAN:  op_d = OP_MSQ;
            OP_MSQ:   op_d = OP_CM;
            OP_CM: begin
              if (sts_i.multi_block) begin
                op_d = OP_MSQD;
              end else begin
                state_d = ST_EMIT;
              end
            end
            OP_MSQD:  op_d = OP_CM2;
            OP_CM2:   op_d = OP_VDIV;
            OP_VDIV:  op_d = OP_SQRT;
            OP_SQRT:  state_d = ST_EMIT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_SIG2;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      second_q <= second_d;
    end
  end

endmodule

### rtl/mcop_dp.sv
// Datapath of the pricer: registers, accumulators, shared multiplier and divider,
// and the square-root iteration. Depends on mcop_pkg, mcop_mul and mcop_div.
`include "assert_macros.svh"
module mcop_dp #(
  parameter int unsigned MAX_BLOCKS    = 65535,
  parameter int unsigned MAX_BLOCK_LEN = 1048575
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcop_pkg::cmd_t                    cmd_i,
  output mcop_pkg::sts_t                    sts_o,
  input  mcop_pkg::in_t                     in_data_i,
  input  logic                              cfg_we_i,
  input  logic [mcop_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcop_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mcop_pkg::out_t                    out_data_o
);
  import mcop_pkg::*;

  localparam logic [19:0] MAX_LEN = 20'(MAX_BLOCK_LEN);
  localparam logic [15:0] MAX_BLK = 16'(MAX_BLOCKS);
  // Reciprocal of ln 2 scaled by 2^32; the quotient estimate is at most one low.
  localparam logic [63:0] LN2_RECIP = 64'((128'd1 << 64) / {64'd0, LN2_Q32});

  function automatic logic [63:0] scale_pow2(input logic [63:0] v,
                                             input logic signed [31:0] e,
                                             input logic [63:0] cap);
    logic [63:0] r;
    logic [31:0] ne;
    ne = 32'(-e);
    r  = '0;
    if (e < 0) begin
      if (e > -32'sd64) begin
        r = v >> ne[5:0];
        if (r > cap) r = cap;
      end
    end else if (v != '0) begin
      if (e >= 32'sd64) r = cap;
      else if (v > (cap >> e[5:0])) r = cap;
      else r = v << e[5:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] spot_q, strike_q;
  logic [15:0] rate_q;
  logic [23:0] mat_q;
  logic [17:0] sigma_q;
  logic        kind_q;
  logic [19:0] blen_q;

  // Accumulated state.
  logic [55:0] acc_q;
  logic [19:0] cnt_q;
  logic [15:0] nblk_q;
  logic [47:0] sm_q;
  logic [63:0] ssq_q;
  logic        out_valid_q;

  // Working registers.
  logic signed [15:0] z_q;
  logic signed [39:0] drift_q;
  logic [63:0]        x_q;
  logic signed [31:0] k_q;
  logic [31:0]        f_q, g_q, mean_q, cm_q, err_q;
  logic [63:0]        t_q, s_q, msq_q, var_q;
  logic [3:0]         n_q;
  out_t               out_q;

  // Square-root iteration.
  logic [63:0] sq_rem_q, sq_res_q, sq_bit_q, sq_sum;
  logic        sq_busy_q, sq_done_q, sq_start;

  logic          mul_start, mul_busy, mul_done;
  logic [63:0]   mul_a, mul_b;
  logic [127:0]  mul_p;
  logic          div_start, div_busy, div_done;
  logic [63:0]   div_num, div_den, div_quo;

  logic [63:0] x_mag, mant, d_val, g_val;
  logic [39:0] drift_mag;
  logic [16:0] z_mag;
  logic [31:0] diff;
  logic [19:0] len_eff;
  logic [32:0] pay;
  logic [56:0] acc_sum;
  logic [48:0] sm_sum;
  logic [64:0] ssq_sum;
  logic [15:0] kq_est;
  logic [47:0] kq_prod;
  logic [63:0] krem0, krem;
  logic        kfix;
  logic [31:0] kq;
  logic        rnz;
  logic        use_mul, use_div;

  assign x_mag     = x_q[63] ? 64'(-x_q) : x_q;
  assign drift_mag = drift_q[39] ? 40'(-drift_q) : 40'(drift_q);
  assign z_mag     = z_q[15] ? 17'(-{z_q[15], z_q}) : {1'b0, z_q};
  assign mant      = 64'((s_q + 64'd2) >> 2);
  assign d_val     = scale_pow2(mant, k_q + 32'sd2, ONE_Q32);
  assign g_val     = scale_pow2(mul_p[63:0], k_q - 32'sd30, U32_MAX64);
  assign len_eff   = (blen_q == '0) ? 20'd1 : ((blen_q > MAX_LEN) ? MAX_LEN : blen_q);
  assign pay       = mul_p[64:32];
  assign acc_sum   = {1'b0, acc_q} + {24'd0, pay};
  assign sm_sum    = {1'b0, sm_q} + {17'd0, mean_q};
  assign ssq_sum   = {1'b0, ssq_q} + {1'b0, mul_p[63:0]};
  assign kq_est    = mul_p[79:64];
  assign kq_prod   = {32'd0, kq_est} * {16'd0, LN2_Q32[31:0]};
  assign krem0     = x_mag - {16'd0, kq_prod};
  assign kfix      = krem0 >= LN2_Q32;
  assign krem      = kfix ? krem0 - LN2_Q32 : krem0;
  assign kq        = {16'd0, kq_est} + {31'd0, kfix};
  assign rnz       = |krem;

  always_comb begin
    if (kind_q) diff = (strike_q > g_q) ? strike_q - g_q : '0;
    else        diff = (g_q > strike_q) ? g_q - strike_q : '0;
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = 64'd1;
    use_mul = 1'b0;
    use_div = 1'b0;
    unique case (cmd_i.op)
      OP_SIG2:  begin use_mul = 1'b1; mul_a = 64'(sigma_q);   mul_b = 64'(sigma_q); end
      OP_DRIFT: begin use_mul = 1'b1; mul_a = 64'(drift_mag); mul_b = 64'(mat_q);   end
      OP_SIGZ:  begin use_mul = 1'b1; mul_a = 64'(sigma_q);   mul_b = 64'(z_mag);   end
      OP_TMUL:  begin use_mul = 1'b1; mul_a = t_q;            mul_b = 64'(f_q);     end
      OP_SPOT:  begin use_mul = 1'b1; mul_a = 64'(spot_q);    mul_b = mant;         end
      OP_DISC:  begin use_mul = 1'b1; mul_a = 64'(rate_q);    mul_b = 64'(mat_q);   end
      OP_PAY:   begin use_mul = 1'b1; mul_a = 64'(diff);      mul_b = d_val;        end
      OP_MSQ:   begin use_mul = 1'b1; mul_a = 64'(mean_q);    mul_b = 64'(mean_q);  end
      OP_CM2:   begin use_mul = 1'b1; mul_a = 64'(cm_q);      mul_b = 64'(cm_q);    end
      OP_KDIV:  begin use_mul = 1'b1; mul_a = x_mag;          mul_b = LN2_RECIP;    end
      OP_TDIV:  begin use_div = 1'b1; div_num = t_q;          div_den = 64'(n_q);   end
      OP_MEAN:  begin use_div = 1'b1; div_num = 64'(acc_q);   div_den = 64'(cnt_q); end
      OP_CM:    begin use_div = 1'b1; div_num = 64'(sm_q);    div_den = 64'(nblk_q); end
      OP_MSQD:  begin use_div = 1'b1; div_num = ssq_q;        div_den = 64'(nblk_q); end
      OP_VDIV:  begin
        use_div = 1'b1;
        div_num = var_q;
        div_den = 64'(16'(nblk_q - 16'd1));
      end
      OP_SQRT:  ;
      default:  ;
    endcase
  end

  assign mul_start = cmd_i.start && use_mul;
  assign div_start = cmd_i.start && use_div;
  assign sq_start  = cmd_i.start && (cmd_i.op == OP_SQRT);

  mcop_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  mcop_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign sts_o.done        = mul_done | div_done | sq_done_q;
  assign sts_o.taylor_last = (n_q == TAYLOR_TERMS);
  assign sts_o.block_end   = ({1'b0, cnt_q} + 21'd1) >= {1'b0, len_eff};
  assign sts_o.multi_block = (nblk_q > 16'd1);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign sq_sum = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
    end else begin
      sq_done_q <= 1'b0;
      if (sq_start) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sq_bit_q == 64'd1) begin
        sq_busy_q <= 1'b0;
        sq_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_rem_q <= var_q;
      sq_res_q <= '0;
      sq_bit_q <= 64'h4000_0000_0000_0000;
    end else if (sq_busy_q) begin
      if (sq_rem_q >= sq_sum) begin
        sq_rem_q <= sq_rem_q - sq_sum;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q      <= 32'd6553600;
      strike_q    <= 32'd6553600;
      rate_q      <= 16'd6554;
      mat_q       <= 24'd65536;
      sigma_q     <= 18'd16384;
      kind_q      <= 1'b0;
      blen_q      <= 20'd10000;
      acc_q       <= '0;
      cnt_q       <= '0;
      nblk_q      <= '0;
      sm_q        <= '0;
      ssq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SPOT:   spot_q   <= cfg_data_i;
          CFG_STRIKE: strike_q <= cfg_data_i;
          CFG_RATE:   rate_q   <= cfg_data_i[15:0];
          CFG_MAT:    mat_q    <= cfg_data_i[23:0];
          CFG_SIGMA:  sigma_q  <= cfg_data_i[17:0];
          CFG_KIND:   kind_q   <= cfg_data_i[0];
          CFG_BLEN:   blen_q   <= cfg_data_i[19:0];
          default:    ;
        endcase
      end
      if (cmd_i.accept && in_data_i.restart) begin
        acc_q  <= '0;
        cnt_q  <= '0;
        nblk_q <= '0;
        sm_q   <= '0;
        ssq_q  <= '0;
      end
      if (sts_o.done) begin
        unique case (cmd_i.op)
          OP_PAY: begin
            acc_q <= acc_sum[56] ? '1 : acc_sum[55:0];
            cnt_q <= cnt_q + 20'd1;
          end
          OP_MEAN: begin
            acc_q <= '0;
            cnt_q <= '0;
          end
          OP_MSQ: begin
            if (nblk_q < MAX_BLK) begin
              nblk_q <= nblk_q + 16'd1;
              sm_q   <= sm_sum[48] ? '1 : sm_sum[47:0];
              ssq_q  <= ssq_sum[64] ? '1 : ssq_sum[63:0];
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      z_q <= in_data_i.gaussian_sample;
    end
    if (sts_o.done) begin
      unique case (cmd_i.op)
        OP_SIG2: drift_q <= $signed({8'd0, rate_q, 16'd0}) - $signed({5'd0, mul_p[35:1]});
        OP_DRIFT: begin
          if (drift_q[39]) x_q <= 64'(-({16'd0, mul_p[63:16]} + 64'(|mul_p[15:0])));
          else             x_q <= {16'd0, mul_p[63:16]};
        end
        OP_SIGZ: begin
          if (z_q[15]) x_q <= x_q - {mul_p[59:0], 4'd0};
          else         x_q <= x_q + {mul_p[59:0], 4'd0};
        end
        OP_KDIV: begin
          k_q <= x_q[63] ? 32'(-(kq + 32'(rnz))) : kq;
          if (x_q[63]) f_q <= rnz ? 32'(LN2_Q32 - krem) : '0;
          else         f_q <= krem[31:0];
          t_q <= ONE_Q32;
          s_q <= ONE_Q32;
          n_q <= 4'd1;
        end
        OP_TMUL: t_q <= mul_p[95:32];
        OP_TDIV: begin
          t_q <= div_quo;
          s_q <= s_q + div_quo;
          n_q <= n_q + 4'd1;
        end
        OP_SPOT: g_q <= g_val[31:0];
        OP_DISC: x_q <= 64'(-mul_p[63:0]);
        OP_MEAN: mean_q <= (|div_quo[63:32]) ? '1 : div_quo[31:0];
        OP_CM: begin
          cm_q  <= (|div_quo[63:32]) ? '1 : div_quo[31:0];
          err_q <= '0;
        end
        OP_MSQD: msq_q <= div_quo;
        OP_CM2:  var_q <= (msq_q > mul_p[63:0]) ? msq_q - mul_p[63:0] : '0;
        OP_VDIV: var_q <= div_quo;
        OP_SQRT: err_q <= sq_res_q[31:0];
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.running_mean  <= cm_q;
      out_q.running_error <= err_q;
      out_q.block_number  <= nblk_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MCOP_ASSERT(a_mul_free, clk_i, rst_ni, mul_start |-> !mul_busy && !div_busy, "multiplier restarted while a unit is busy")
  `MCOP_ASSERT(a_div_free, clk_i, rst_ni, div_start |-> !div_busy && !mul_busy, "divider restarted while a unit is busy")
  `MCOP_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > MAX_LEN, "sample count beyond the block length limit")
  `MCOP_ASSERT_NEVER(a_blk_bound, clk_i, rst_ni, nblk_q > MAX_BLK, "block counter beyond its limit")

endmodule
